// ===== design/chr_pkg.sv =====
// ----------------------------------------------------------------------------
// chr_pkg
// Shared types, constants and codes for the channel hop ranker.
// ----------------------------------------------------------------------------
`default_nettype none

package chr_pkg;

  localparam int MAX_CANDIDATES_DEF = 8;
  localparam int MAX_VISITS_DEF     = 16;

  localparam int CHAN_W  = 8;
  localparam int TIME_W  = 32;
  localparam int CNT_W   = 16;
  localparam int SCORE_W = 19;
  localparam int SUM_W   = 23;
  localparam int FRESH_W = 5;
  localparam int SKIP_W  = 9;
  localparam int CFG_W   = 64;
  localparam int CIDX_W  = 3;

  localparam logic [SUM_W-1:0]   SCORE_CAP = {SUM_W{1'b1}};
  localparam logic [FRESH_W-1:0] FRESH_CAP = {FRESH_W{1'b1}};

  typedef enum logic [CIDX_W-1:0] {
    CFG_CAND_LIST  = 3'd0,
    CFG_CAND_COUNT = 3'd1,
    CFG_HOME       = 3'd2,
    CFG_BOOT       = 3'd3,
    CFG_WINDOW     = 3'd4,
    CFG_MAX_AGE    = 3'd5
  } cfg_idx_e;

  localparam logic OP_RECORD = 1'b0;
  localparam logic OP_QUERY  = 1'b1;

  typedef struct packed {
    logic [63:0]       cand_list;
    logic [3:0]        cand_count;
    logic [CHAN_W-1:0] home;
    logic [CHAN_W-1:0] boot;
    logic [4:0]        window;
    logic [TIME_W-1:0] max_age;
  } cfg_t;

  typedef struct packed {
    logic latch;
    logic rec;
    logic load;
    logic read;
    logic drain;
    logic rank;
    logic emit;
  } cmd_t;

  typedef struct packed {
    logic reads_done;
    logic last_slot;
  } stat_t;

endpackage

`default_nettype wire

// ===== design/channel_hop_ranker.sv =====
// ----------------------------------------------------------------------------
// channel_hop_ranker
// Keeps a ring of recent visits per candidate channel and, on a query, ranks
// the channels by the summed score of their fresh visits.
// ----------------------------------------------------------------------------
//
//  Channel   Direction  Handshake                 Payload
//  item      in         start & !busy             op, channel, time, counters,
//                                                 exclude_channel, skip_mask
//  result    out        result_valid_o (1 cycle)  ranked_channel .. last
//  config    in         cfg_we_i                  cfg_idx_i, cfg_wdata_i
//
//  A record item is captured, then written to the store in one write.
//  A query runs, per slot: a load, the visit reads from the store, one a cycle
//  (one read port), a done check, and a drain. Then the slots are ranked in
//  turn, and one result per slot is emitted.
//  Reset clears the ring pointers and fill counts; the visit store itself is
//  never cleared, since reads stay below the fill count.
//  Results are strobed for a single cycle; the receiver cannot stall them.
// ----------------------------------------------------------------------------
`default_nettype none

module channel_hop_ranker
  import chr_pkg::*;
#(
  parameter int MAX_CANDIDATES = MAX_CANDIDATES_DEF,
  parameter int MAX_VISITS     = MAX_VISITS_DEF
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               cfg_we_i,
  input  wire logic [CIDX_W-1:0]  cfg_idx_i,
  input  wire logic [CFG_W-1:0]   cfg_wdata_i,
  input  wire logic               start,
  output logic                    busy,
  input  wire logic               op_i,
  input  wire logic [CHAN_W-1:0]  channel_i,
  input  wire logic [TIME_W-1:0]  time_ms_i,
  input  wire logic [CNT_W-1:0]   false_alarms_i,
  input  wire logic [CNT_W-1:0]   busy_count_i,
  input  wire logic [CNT_W-1:0]   own_count_i,
  input  wire logic [CNT_W-1:0]   foreign_count_i,
  input  wire logic [CHAN_W-1:0]  exclude_channel_i,
  input  wire logic [SKIP_W-1:0]  skip_mask_i,
  output logic                    result_valid_o,
  output logic      [CHAN_W-1:0]  ranked_channel_o,
  output logic      [FRESH_W-1:0] fresh_visits_o,
  output logic      [SUM_W-1:0]   total_score_o,
  output logic                    is_ranked_o,
  output logic      [CHAN_W-1:0]  best_channel_o,
  output logic                    best_found_o,
  output logic                    last_o
);

  cfg_t  cfg_q;
  cmd_t  cmd;
  stat_t stat;
  logic  busy_o;

  assign busy = busy_o;

  // Configuration registers; writes beyond the list are dropped.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.cand_list  <= '0;
      cfg_q.cand_count <= '0;
      cfg_q.home       <= '0;
      cfg_q.boot       <= '0;
      cfg_q.window     <= 5'd16;
      cfg_q.max_age    <= 32'd1000;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_CAND_LIST:  cfg_q.cand_list  <= cfg_wdata_i;
        CFG_CAND_COUNT: cfg_q.cand_count <= cfg_wdata_i[3:0];
        CFG_HOME:       cfg_q.home       <= cfg_wdata_i[CHAN_W-1:0];
        CFG_BOOT:       cfg_q.boot       <= cfg_wdata_i[CHAN_W-1:0];
        CFG_WINDOW:     cfg_q.window     <= cfg_wdata_i[4:0];
        CFG_MAX_AGE:    cfg_q.max_age    <= cfg_wdata_i[TIME_W-1:0];
        default: begin
        end
      endcase
    end
  end

  chr_ctrl u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start),
    .op_i    (op_i),
    .stat_i  (stat),
    .cmd_o   (cmd),
    .busy_o  (busy_o)
  );

  chr_dp #(
    .MAX_CANDIDATES (MAX_CANDIDATES),
    .MAX_VISITS     (MAX_VISITS)
  ) u_dp (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cmd_i             (cmd),
    .stat_o            (stat),
    .cfg_i             (cfg_q),
    .channel_i         (channel_i),
    .time_ms_i         (time_ms_i),
    .false_alarms_i    (false_alarms_i),
    .busy_count_i      (busy_count_i),
    .own_count_i       (own_count_i),
    .foreign_count_i   (foreign_count_i),
    .exclude_channel_i (exclude_channel_i),
    .skip_mask_i       (skip_mask_i),
    .result_valid_o    (result_valid_o),
    .ranked_channel_o  (ranked_channel_o),
    .fresh_visits_o    (fresh_visits_o),
    .total_score_o     (total_score_o),
    .is_ranked_o       (is_ranked_o),
    .best_channel_o    (best_channel_o),
    .best_found_o      (best_found_o),
    .last_o            (last_o)
  );

  // More results pending means the query is still in flight.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && !last_o |-> busy_o)
    else $error("result strobe ahead of last while idle");

  // A missing best pick always reads as channel zero.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && !best_found_o |-> best_channel_o == '0)
    else $error("best channel set without a pick");

  // A record goes busy for its store write and returns to idle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy_o && (op_i == OP_RECORD) |=> busy_o ##1 !busy_o)
    else $error("record did not take exactly one store cycle");

  // The final result of a query ends the burst.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && last_o |=> !result_valid_o)
    else $error("result after the last entry");

endmodule

`default_nettype wire

// ===== design/chr_ram.sv =====
// ----------------------------------------------------------------------------
// chr_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
`default_nettype none

module chr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    waddr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  input  wire logic [AW-1:0]    raddr_i,
  output logic      [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

`default_nettype wire

// ===== design/chr_ctrl.sv =====
// ----------------------------------------------------------------------------
// chr_ctrl
// Sequencer: record, per-slot scan, ranking pass and result emission.
// ----------------------------------------------------------------------------
`default_nettype none

module chr_ctrl
  import chr_pkg::*;
(
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  input  wire logic  start_i,
  input  wire logic  op_i,
  input  stat_t      stat_i,
  output cmd_t       cmd_o,
  output logic       busy_o
);

  typedef enum logic [6:0] {
    ST_IDLE  = 7'b0000001,
    ST_REC   = 7'b0000010,
    ST_LOAD  = 7'b0000100,
    ST_SCAN  = 7'b0001000,
    ST_DRAIN = 7'b0010000,
    ST_RANK  = 7'b0100000,
    ST_EMIT  = 7'b1000000
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      ST_IDLE: begin
        if (start_i) begin
          cmd_o.latch = 1'b1;
          state_d     = (op_i == OP_QUERY) ? ST_LOAD : ST_REC;
        end
      end
      ST_REC: begin
        cmd_o.rec = 1'b1;
        state_d   = ST_IDLE;
      end
      ST_LOAD: begin
        cmd_o.load = 1'b1;
        state_d    = ST_SCAN;
      end
      ST_SCAN: begin
        if (stat_i.reads_done) begin
          state_d = ST_DRAIN;
        end else begin
          cmd_o.read = 1'b1;
        end
      end
      ST_DRAIN: begin
        cmd_o.drain = 1'b1;
        state_d     = stat_i.last_slot ? ST_RANK : ST_LOAD;
      end
      ST_RANK: begin
        cmd_o.rank = 1'b1;
        if (stat_i.last_slot) begin
          state_d = ST_EMIT;
        end
      end
      ST_EMIT: begin
        cmd_o.emit = 1'b1;
        if (stat_i.last_slot) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign busy_o = (state_q != ST_IDLE);

endmodule

`default_nettype wire

// ===== design/chr_dp.sv =====
// ----------------------------------------------------------------------------
// chr_dp
// Datapath: slot table, visit store, freshness accumulator, rank and output.
// ----------------------------------------------------------------------------
`default_nettype none

module chr_dp
  import chr_pkg::*;
#(
  parameter int MAX_CANDIDATES = MAX_CANDIDATES_DEF,
  parameter int MAX_VISITS     = MAX_VISITS_DEF
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  cmd_t                    cmd_i,
  output stat_t                   stat_o,
  input  cfg_t                    cfg_i,
  input  wire logic [CHAN_W-1:0]  channel_i,
  input  wire logic [TIME_W-1:0]  time_ms_i,
  input  wire logic [CNT_W-1:0]   false_alarms_i,
  input  wire logic [CNT_W-1:0]   busy_count_i,
  input  wire logic [CNT_W-1:0]   own_count_i,
  input  wire logic [CNT_W-1:0]   foreign_count_i,
  input  wire logic [CHAN_W-1:0]  exclude_channel_i,
  input  wire logic [SKIP_W-1:0]  skip_mask_i,
  output logic                    result_valid_o,
  output logic      [CHAN_W-1:0]  ranked_channel_o,
  output logic      [FRESH_W-1:0] fresh_visits_o,
  output logic      [SUM_W-1:0]   total_score_o,
  output logic                    is_ranked_o,
  output logic      [CHAN_W-1:0]  best_channel_o,
  output logic                    best_found_o,
  output logic                    last_o
);

  localparam int SLOTS  = MAX_CANDIDATES + 1;
  localparam int SIDX_W = $clog2(SLOTS);
  localparam int NS_W   = $clog2(SLOTS + 1);
  localparam int HEAD_W = (MAX_VISITS > 1) ? $clog2(MAX_VISITS) : 1;
  localparam int FILL_W = $clog2(MAX_VISITS + 1);
  localparam int DEPTH  = SLOTS * MAX_VISITS;
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int RAM_W  = TIME_W + SCORE_W;
  localparam int KEY_W  = 1 + SUM_W + 2;

  // Slot table from configuration
  logic [3:0]        cnt_sat;
  logic              home_listed;
  logic [CHAN_W-1:0] chan [SLOTS];
  logic [NS_W-1:0]   nslots;

  always_comb begin
    cnt_sat     = (cfg_i.cand_count > 4'(MAX_CANDIDATES)) ? 4'(MAX_CANDIDATES)
                                                          : cfg_i.cand_count;
    home_listed = 1'b0;
    for (int i = 0; i < MAX_CANDIDATES; i++) begin
      if ((4'(i) < cnt_sat) && (cfg_i.cand_list[8*i +: 8] == cfg_i.home)) begin
        home_listed = 1'b1;
      end
    end
    for (int i = 0; i < SLOTS; i++) begin
      if (4'(i) < cnt_sat) begin
        chan[i] = cfg_i.cand_list[8*(i % MAX_CANDIDATES) +: 8];
      end else if ((4'(i) == cnt_sat) && !home_listed) begin
        chan[i] = cfg_i.home;
      end else begin
        chan[i] = '0;
      end
    end
    nslots = NS_W'(cnt_sat) + NS_W'(!home_listed);
  end

  // Latched item
  logic [CHAN_W-1:0]  ch_q, excl_q;
  logic [TIME_W-1:0]  now_q;
  logic [SCORE_W-1:0] score_q, score_d;
  logic [SKIP_W-1:0]  skip_q;

  always_comb begin
    score_d = SCORE_W'(false_alarms_i) + SCORE_W'({foreign_count_i, 2'b00});
    if (busy_count_i > own_count_i) begin
      score_d = score_d + SCORE_W'(busy_count_i - own_count_i);
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.latch) begin
      ch_q    <= channel_i;
      now_q   <= time_ms_i;
      score_q <= score_d;
      excl_q  <= exclude_channel_i;
      skip_q  <= skip_mask_i;
    end
  end

  // Slot lookup for a record
  logic              hit;
  logic [SIDX_W-1:0] hit_slot;

  always_comb begin
    hit      = 1'b0;
    hit_slot = '0;
    for (int i = SLOTS - 1; i >= 0; i--) begin
      if ((NS_W'(i) < nslots) && (chan[i] == ch_q)) begin
        hit      = 1'b1;
        hit_slot = SIDX_W'(i);
      end
    end
  end

  // Ring pointers, one read port selected by phase
  logic [HEAD_W-1:0] head_q [SLOTS];
  logic [FILL_W-1:0] fill_q [SLOTS];
  logic [SIDX_W-1:0] slot_q, ptr;
  logic [HEAD_W-1:0] head_sel, head_inc;
  logic [FILL_W-1:0] fill_sel, fill_inc, fill_new, wcap;
  logic              rec_we;

  assign ptr      = cmd_i.rec ? hit_slot : slot_q;
  assign head_sel = head_q[ptr];
  assign fill_sel = fill_q[ptr];
  assign rec_we   = cmd_i.rec && hit;
  assign head_inc = (head_sel == HEAD_W'(MAX_VISITS - 1)) ? '0 : head_sel + HEAD_W'(1);
  assign wcap     = (32'(cfg_i.window) > 32'(MAX_VISITS)) ? FILL_W'(MAX_VISITS)
                                                          : FILL_W'(cfg_i.window);
  assign fill_inc = (fill_sel < FILL_W'(MAX_VISITS)) ? fill_sel + FILL_W'(1) : fill_sel;
  assign fill_new = (fill_inc > wcap) ? wcap : fill_inc;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < SLOTS; i++) begin
        head_q[i] <= '0;
        fill_q[i] <= '0;
      end
    end else if (rec_we) begin
      head_q[hit_slot] <= head_inc;
      fill_q[hit_slot] <= fill_new;
    end
  end

  // Visit store
  logic [FILL_W-1:0] kk_q;
  logic [HEAD_W-1:0] idx_q;
  logic [ADDR_W-1:0] waddr, raddr;
  logic [RAM_W-1:0]  rdata;

  assign waddr = ADDR_W'(hit_slot) * ADDR_W'(MAX_VISITS) + ADDR_W'(head_sel);
  assign raddr = ADDR_W'(slot_q) * ADDR_W'(MAX_VISITS) + ADDR_W'(idx_q);

  chr_ram #(
    .WIDTH (RAM_W),
    .DEPTH (DEPTH)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (rec_we),
    .waddr_i (waddr),
    .wdata_i ({now_q, score_q}),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  // Freshness accumulator
  logic                rd_vld_q;
  logic [SUM_W-1:0]    acc_q, acc_nxt;
  logic [FILL_W-1:0]   fcnt_q, fcnt_nxt;
  logic [TIME_W:0]     age;
  logic                is_fresh;
  logic [SUM_W:0]      acc_sum;

  assign age      = {1'b0, now_q} - {1'b0, rdata[RAM_W-1 -: TIME_W]};
  assign is_fresh = age[TIME_W] || (age[TIME_W-1:0] <= cfg_i.max_age);
  assign acc_sum  = {1'b0, acc_q} + (SUM_W + 1)'(rdata[SCORE_W-1:0]);

  always_comb begin
    acc_nxt  = acc_q;
    fcnt_nxt = fcnt_q;
    if (rd_vld_q && is_fresh) begin
      acc_nxt  = acc_sum[SUM_W] ? SCORE_CAP : acc_sum[SUM_W-1:0];
      fcnt_nxt = fcnt_q + FILL_W'(1);
    end
  end

  logic last_slot;
  assign last_slot         = ((NS_W'(slot_q) + NS_W'(1)) == nslots);
  assign stat_o.reads_done = (kk_q == fill_sel);
  assign stat_o.last_slot  = last_slot;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slot_q   <= '0;
      rd_vld_q <= 1'b0;
    end else begin
      rd_vld_q <= cmd_i.read;
      if (cmd_i.latch) begin
        slot_q <= '0;
      end else if (cmd_i.drain || cmd_i.rank || cmd_i.emit) begin
        slot_q <= last_slot ? '0 : slot_q + SIDX_W'(1);
      end
    end
  end

  logic [FILL_W-1:0] fresh_q [SLOTS];
  logic [SUM_W-1:0]  sum_q [SLOTS];

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      kk_q   <= '0;
      idx_q  <= (head_sel == '0) ? HEAD_W'(MAX_VISITS - 1) : head_sel - HEAD_W'(1);
      acc_q  <= '0;
      fcnt_q <= '0;
    end else begin
      acc_q  <= acc_nxt;
      fcnt_q <= fcnt_nxt;
      if (cmd_i.read) begin
        kk_q  <= kk_q + FILL_W'(1);
        idx_q <= (idx_q == '0) ? HEAD_W'(MAX_VISITS - 1) : idx_q - HEAD_W'(1);
      end
    end
    if (cmd_i.drain) begin
      fresh_q[slot_q] <= fcnt_nxt;
      sum_q[slot_q]   <= acc_nxt;
    end
  end

  // Rank: position of one slot per cycle
  logic [KEY_W-1:0]  key [SLOTS];
  logic [SIDX_W-1:0] ord_q [SLOTS];
  logic [SIDX_W-1:0] rd_slot, pos, best_pos_q;
  logic [KEY_W-1:0]  own_key;
  logic              own_ranked, eligible;
  logic [CHAN_W-1:0] best_chan_q;
  logic              best_found_q;

  always_comb begin
    for (int i = 0; i < SLOTS; i++) begin
      if (fresh_q[i] >= FILL_W'(2)) begin
        key[i] = {1'b0, sum_q[i], chan[i] != cfg_i.boot, chan[i] != cfg_i.home};
      end else begin
        key[i] = {1'b1, {(KEY_W - 1){1'b0}}};
      end
    end
  end

  assign rd_slot    = cmd_i.emit ? ord_q[slot_q] : slot_q;
  assign own_key    = key[rd_slot];
  assign own_ranked = (fresh_q[rd_slot] >= FILL_W'(2));
  assign eligible   = own_ranked && (chan[rd_slot] != excl_q) && !skip_q[rd_slot];

  always_comb begin
    pos = '0;
    for (int j = 0; j < SLOTS; j++) begin
      if ((NS_W'(j) < nslots) && (SIDX_W'(j) != rd_slot)) begin
        if ((key[j] < own_key) || ((SIDX_W'(j) < rd_slot) && (key[j] == own_key))) begin
          pos = pos + SIDX_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.rank) begin
      ord_q[pos] <= slot_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      best_found_q <= 1'b0;
      best_chan_q  <= '0;
      best_pos_q   <= '0;
    end else if (cmd_i.latch) begin
      best_found_q <= 1'b0;
      best_chan_q  <= '0;
    end else if (cmd_i.rank && eligible && (!best_found_q || (pos < best_pos_q))) begin
      best_found_q <= 1'b1;
      best_chan_q  <= chan[rd_slot];
      best_pos_q   <= pos;
    end
  end

  // Result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      result_valid_o <= 1'b0;
    end else begin
      result_valid_o <= cmd_i.emit;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      ranked_channel_o <= chan[rd_slot];
      fresh_visits_o   <= (32'(fresh_q[rd_slot]) > 32'(FRESH_CAP)) ? FRESH_CAP
                                                                  : FRESH_W'(fresh_q[rd_slot]);
      total_score_o    <= sum_q[rd_slot];
      is_ranked_o      <= own_ranked;
      best_channel_o   <= best_chan_q;
      best_found_o     <= best_found_q;
      last_o           <= last_slot;
    end
  end

endmodule

`default_nettype wire

// ===== tb/chr_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// chr_checker
// Watches the config, item and result channels of the channel hop ranker,
// keeps its own copy of the visit rings, predicts every ranking entry and
// compares the results against them in order.
// ----------------------------------------------------------------------------
module chr_checker
  import chr_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [CIDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_W-1:0]   cfg_wdata_i,
  input  logic               start_i,
  input  logic               busy_i,
  input  logic               op_i,
  input  logic [CHAN_W-1:0]  channel_i,
  input  logic [TIME_W-1:0]  time_ms_i,
  input  logic [CNT_W-1:0]   false_alarms_i,
  input  logic [CNT_W-1:0]   busy_count_i,
  input  logic [CNT_W-1:0]   own_count_i,
  input  logic [CNT_W-1:0]   foreign_count_i,
  input  logic [CHAN_W-1:0]  exclude_channel_i,
  input  logic [SKIP_W-1:0]  skip_mask_i,
  input  logic               result_valid_i,
  input  logic [CHAN_W-1:0]  ranked_channel_i,
  input  logic [FRESH_W-1:0] fresh_visits_i,
  input  logic [SUM_W-1:0]   total_score_i,
  input  logic               is_ranked_i,
  input  logic [CHAN_W-1:0]  best_channel_i,
  input  logic               best_found_i,
  input  logic               last_i,
  output int                 fail_count_o,
  output int                 pending_o
);

  localparam int NSLOT  = MAX_CANDIDATES_DEF + 1;
  localparam int NVIS   = MAX_VISITS_DEF;
  localparam int QDEPTH = 64;

  typedef struct packed {
    logic [CHAN_W-1:0]  chan;
    logic [FRESH_W-1:0] fresh;
    logic [SUM_W-1:0]   score;
    logic               ranked;
    logic [CHAN_W-1:0]  best;
    logic               found;
    logic               last;
  } rank_entry_t;

  rank_entry_t ranking_mem [QDEPTH];
  int unsigned wr_cnt, rd_cnt;
  int          fails = 0;
  cfg_t        cfg;
  logic [TIME_W-1:0]  visit_at   [NSLOT][NVIS];
  logic [SCORE_W-1:0] visit_cost [NSLOT][NVIS];
  int unsigned        ring_fill  [NSLOT];
  int unsigned        ring_head  [NSLOT];

  assign fail_count_o = fails;

  // Build the slot channel list: listed channels, then home if absent.
  function automatic int slot_channels(output logic [CHAN_W-1:0] chans [NSLOT]);
    int n;
    bit home_listed;
    n = (cfg.cand_count > MAX_CANDIDATES_DEF) ? MAX_CANDIDATES_DEF : int'(cfg.cand_count);
    home_listed = 0;
    foreach (chans[i]) chans[i] = '0;
    for (int i = 0; i < n; i++) begin
      chans[i] = cfg.cand_list[8*i +: 8];
      if (chans[i] == cfg.home) home_listed = 1;
    end
    if (!home_listed) begin
      chans[n] = cfg.home;
      n++;
    end
    return n;
  endfunction

  function automatic bit ranks_ahead(logic [CHAN_W-1:0] ca, bit ra, int unsigned sa,
                                     logic [CHAN_W-1:0] cb, bit rb, int unsigned sb);
    if (ra != rb) return ra;
    if (!ra) return 0;
    if (sa != sb) return sa < sb;
    if ((ca == cfg.boot) != (cb == cfg.boot)) return ca == cfg.boot;
    if ((ca == cfg.home) != (cb == cfg.home)) return ca == cfg.home;
    return 0;
  endfunction

  task automatic store_visit();
    logic [CHAN_W-1:0] chans [NSLOT];
    int n, s;
    int unsigned win, pos, busy_net;
    n = slot_channels(chans);
    s = -1;
    for (int i = n - 1; i >= 0; i--) if (chans[i] == channel_i) s = i;
    if (s < 0) return;  // unknown channel: drop the visit
    win = (cfg.window > NVIS) ? NVIS : int'(cfg.window);
    busy_net = (busy_count_i > own_count_i) ? 32'(busy_count_i - own_count_i) : 0;
    pos = ring_head[s] % NVIS;
    visit_at[s][pos]   = time_ms_i;
    visit_cost[s][pos] = SCORE_W'(false_alarms_i + busy_net + 4 * foreign_count_i);
    ring_head[s] = (pos + 1) % NVIS;
    if (ring_fill[s] < NVIS) ring_fill[s]++;
    if (ring_fill[s] > win) ring_fill[s] = win;
  endtask

  task automatic rank_channels();
    logic [CHAN_W-1:0] chans [NSLOT];
    int unsigned fresh [NSLOT];
    int unsigned sum   [NSLOT];
    bit          ranked[NSLOT];
    int          ord   [NSLOT];
    int n, j, e;
    int unsigned idx;
    longint age;
    logic [CHAN_W-1:0] best;
    bit found;
    rank_entry_t ent;
    n = slot_channels(chans);
    for (int s = 0; s < n; s++) begin
      fresh[s] = 0;
      sum[s] = 0;
      for (int k = 0; k < int'(ring_fill[s]) && k < NVIS; k++) begin
        idx = (ring_head[s] + NVIS - 1 - k) % NVIS;
        age = longint'(time_ms_i) - longint'(visit_at[s][idx]);
        if (age > longint'(cfg.max_age)) continue;
        fresh[s]++;
        sum[s] += visit_cost[s][idx];
        if (sum[s] > SCORE_CAP) sum[s] = SCORE_CAP;
      end
      ranked[s] = fresh[s] >= 2;
    end
    // Stable insertion sort of slot indexes.
    for (int s = 0; s < n; s++) begin
      j = s;
      while (j > 0 && ranks_ahead(chans[s], ranked[s], sum[s],
                                  chans[ord[j-1]], ranked[ord[j-1]], sum[ord[j-1]])) begin
        ord[j] = ord[j-1];
        j--;
      end
      ord[j] = s;
    end
    best = '0;
    found = 0;
    for (int k = 0; k < n && !found; k++) begin
      e = ord[k];
      if (ranked[e] && chans[e] != exclude_channel_i && !skip_mask_i[e]) begin
        best = chans[e];
        found = 1;
      end
    end
    for (int k = 0; k < n; k++) begin
      e = ord[k];
      ent.chan   = chans[e];
      ent.fresh  = (fresh[e] > FRESH_CAP) ? FRESH_CAP : fresh[e][FRESH_W-1:0];
      ent.score  = sum[e][SUM_W-1:0];
      ent.ranked = ranked[e];
      ent.best   = best;
      ent.found  = found;
      ent.last   = (k == n - 1);
      ranking_mem[wr_cnt % QDEPTH] = ent;
      wr_cnt++;
    end
  endtask

  task automatic check_entry();
    rank_entry_t want, got;
    got = '{ranked_channel_i, fresh_visits_i, total_score_i, is_ranked_i,
            best_channel_i, best_found_i, last_i};
    if (wr_cnt == rd_cnt) begin
      fails++;
      if (fails <= 10)
        $display("%0t: result with nothing expected: chan=%0d", $realtime, got.chan);
      return;
    end
    want = ranking_mem[rd_cnt % QDEPTH];
    rd_cnt++;
    if (got !== want) begin
      fails++;
      if (fails <= 10)
        $display({"%0t: mismatch exp chan=%0d fresh=%0d score=%0d ranked=%0b best=%0d",
                  " found=%0b last=%0b | got chan=%0d fresh=%0d score=%0d ranked=%0b",
                  " best=%0d found=%0b last=%0b"},
                 $realtime, want.chan, want.fresh, want.score, want.ranked, want.best,
                 want.found, want.last, got.chan, got.fresh, got.score, got.ranked,
                 got.best, got.found, got.last);
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg = '{cand_list: '0, cand_count: '0, home: '0, boot: '0,
              window: 5'd16, max_age: 32'd1000};
      foreach (ring_fill[i]) begin
        ring_fill[i] = 0;
        ring_head[i] = 0;
      end
      wr_cnt = 0;
      rd_cnt = 0;
    end else begin
      if (result_valid_i) check_entry();
      if (cfg_we_i) begin
        case (cfg_idx_e'(cfg_idx_i))
          CFG_CAND_LIST:  cfg.cand_list  = cfg_wdata_i;
          CFG_CAND_COUNT: cfg.cand_count = cfg_wdata_i[3:0];
          CFG_HOME:       cfg.home       = cfg_wdata_i[7:0];
          CFG_BOOT:       cfg.boot       = cfg_wdata_i[7:0];
          CFG_WINDOW:     cfg.window     = cfg_wdata_i[4:0];
          CFG_MAX_AGE:    cfg.max_age    = cfg_wdata_i[31:0];
          default: ;
        endcase
      end
      if (start_i && !busy_i) begin
        if (op_i == OP_RECORD) store_visit();
        else rank_channels();
      end
    end
    pending_o = int'(wr_cnt - rd_cnt);
  end

endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Stimulus and verdict for the channel hop ranker: directed visits and queries
// for ties, stale and future visits, floors and saturation, then random phases
// under varied configurations. The checker predicts and compares.
// ----------------------------------------------------------------------------
module tb_top;
  import chr_pkg::*;

  localparam int QUIET_LIMIT = 3000;  // cycles with no handshake before giving up
  localparam int SETTLE      = 200;   // covers the longest query walk

  logic               clk_i;
  logic               rst_ni;
  logic               cfg_we_i;
  logic [CIDX_W-1:0]  cfg_idx_i;
  logic [CFG_W-1:0]   cfg_wdata_i;
  logic               start;
  logic               busy;
  logic               op_i;
  logic [CHAN_W-1:0]  channel_i;
  logic [TIME_W-1:0]  time_ms_i;
  logic [CNT_W-1:0]   false_alarms_i;
  logic [CNT_W-1:0]   busy_count_i;
  logic [CNT_W-1:0]   own_count_i;
  logic [CNT_W-1:0]   foreign_count_i;
  logic [CHAN_W-1:0]  exclude_channel_i;
  logic [SKIP_W-1:0]  skip_mask_i;
  logic               result_valid_o;
  logic [CHAN_W-1:0]  ranked_channel_o;
  logic [FRESH_W-1:0] fresh_visits_o;
  logic [SUM_W-1:0]   total_score_o;
  logic               is_ranked_o;
  logic [CHAN_W-1:0]  best_channel_o;
  logic               best_found_o;
  logic               last_o;

  int fail_count;
  int pending;

  // Stimulus-side copy of the slot setup, used to aim visits, exclusions and the boot pick at slots.
  logic [63:0]       list_sel;
  logic [3:0]        count_sel;
  logic [CHAN_W-1:0] home_sel;
  logic [TIME_W-1:0] now_ms;

  channel_hop_ranker uut (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_idx_i, .cfg_wdata_i, .start, .busy,
    .op_i, .channel_i, .time_ms_i, .false_alarms_i, .busy_count_i, .own_count_i,
    .foreign_count_i, .exclude_channel_i, .skip_mask_i, .result_valid_o,
    .ranked_channel_o, .fresh_visits_o, .total_score_o, .is_ranked_o,
    .best_channel_o, .best_found_o, .last_o
  );

  chr_checker u_checker (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_idx_i, .cfg_wdata_i, .start_i(start),
    .busy_i(busy), .op_i, .channel_i, .time_ms_i, .false_alarms_i, .busy_count_i,
    .own_count_i, .foreign_count_i, .exclude_channel_i, .skip_mask_i,
    .result_valid_i(result_valid_o), .ranked_channel_i(ranked_channel_o),
    .fresh_visits_i(fresh_visits_o), .total_score_i(total_score_o),
    .is_ranked_i(is_ranked_o), .best_channel_i(best_channel_o),
    .best_found_i(best_found_o), .last_i(last_o),
    .fail_count_o(fail_count), .pending_o(pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Watchdog: count cycles with no item, result or register write.
  initial begin : watchdog
    int quiet;
    quiet = 0;
    forever begin
      @(posedge clk_i);
      if ((start && !busy) || result_valid_o || cfg_we_i) quiet = 0;
      else quiet++;
      if (quiet >= QUIET_LIMIT) begin
        $display("tb: failure");
        $finish;
      end
    end
  end

  // Counter value: mostly random, with the extremes often.
  function automatic logic [CNT_W-1:0] any_count();
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return '1;
      2:       return CNT_W'($urandom_range(0, 20));
      default: return CNT_W'($urandom);
    endcase
  endfunction

  // Channel of a random slot (home included) under the current setup.
  function automatic logic [CHAN_W-1:0] slot_channel();
    int n, k;
    n = (count_sel > 8) ? 8 : int'(count_sel);
    k = $urandom_range(0, n);
    return (k == n) ? home_sel : list_sel[8*k +: 8];
  endfunction

  // Hold the write enable for all six registers, then drop it once.
  task automatic set_registers(logic [63:0] list, logic [3:0] count, logic [7:0] home,
                               logic [7:0] boot, logic [4:0] window, logic [31:0] age);
    logic [63:0] vals [6];
    vals = '{list, 64'(count), 64'(home), 64'(boot), 64'(window), 64'(age)};
    for (int i = 0; i < 6; i++) begin
      cfg_we_i    <= 1'b1;
      cfg_idx_i   <= CIDX_W'(i);
      cfg_wdata_i <= vals[i];
      @(posedge clk_i);
    end
    cfg_we_i <= 1'b0;
    list_sel  = list;
    count_sel = count;
    home_sel  = home;
  endtask

  // Drive one item and hold it until the block takes it. Leave start high.
  task automatic send(logic op, logic [7:0] chan, logic [31:0] t, logic [15:0] fa,
                      logic [15:0] bc, logic [15:0] oc, logic [15:0] fc,
                      logic [7:0] excl, logic [8:0] skip);
    start             <= 1'b1;
    op_i              <= op;
    channel_i         <= chan;
    time_ms_i         <= t;
    false_alarms_i    <= fa;
    busy_count_i      <= bc;
    own_count_i       <= oc;
    foreign_count_i   <= fc;
    exclude_channel_i <= excl;
    skip_mask_i       <= skip;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
  endtask

  task automatic visit(logic [7:0] chan, logic [31:0] t, logic [15:0] fa,
                       logic [15:0] bc, logic [15:0] oc, logic [15:0] fc);
    send(OP_RECORD, chan, t, fa, bc, oc, fc, 8'($urandom), 9'($urandom));
  endtask

  task automatic query(logic [31:0] t, logic [7:0] excl, logic [8:0] skip);
    send(OP_QUERY, 8'($urandom), t, any_count(), any_count(), any_count(), any_count(),
         excl, skip);
  endtask

  // Random pause between items: mostly none or short, a few long.
  task automatic pause();
    int n;
    case ($urandom_range(0, 9))
      0, 1, 2, 3: n = 0;
      9:          n = $urandom_range(20, 60);
      default:    n = $urandom_range(1, 4);
    endcase
    if (n > 0) begin
      start <= 1'b0;
      repeat (n) @(posedge clk_i);
    end
  endtask

  // Let every expected entry arrive, then let a trailing record finish.
  task automatic drain();
    start <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
  endtask

  task automatic random_phase(int items);
    logic [7:0] ch;
    for (int i = 0; i < items; i++) begin
      now_ms += $urandom_range(0, 250);
      if ($urandom_range(0, 39) == 0) now_ms = $urandom;  // jump anywhere
      case ($urandom_range(0, 19))
        0, 1, 2: query(now_ms, ($urandom_range(0, 1) ? slot_channel() : 8'($urandom)),
                       ($urandom_range(0, 2) == 0) ? 9'($urandom) : 9'd0);
        3:       visit(8'($urandom), now_ms, any_count(), any_count(), any_count(),
                       any_count());
        default: begin
          ch = slot_channel();
          // Mostly recent visits; some stale, some dated after the query time.
          visit(ch, now_ms - $urandom_range(0, 1500) + (($urandom_range(0, 9) == 0) ? 3000 : 0),
                any_count(), any_count(), any_count(), any_count());
        end
      endcase
      pause();
    end
    query(now_ms, 8'($urandom), 9'($urandom));
    drain();
  endtask

  initial begin
    logic [63:0] list;
    logic [7:0]  home, boot;
    rst_ni            = 1'b0;
    cfg_we_i          = 1'b0;
    cfg_idx_i         = '0;
    cfg_wdata_i       = '0;
    start             = 1'b0;
    op_i              = OP_RECORD;
    channel_i         = '0;
    time_ms_i         = '0;
    false_alarms_i    = '0;
    busy_count_i      = '0;
    own_count_i       = '0;
    foreign_count_i   = '0;
    exclude_channel_i = '0;
    skip_mask_i       = '0;
    list_sel          = '0;
    count_sel         = '0;
    home_sel          = '0;
    now_ms            = 32'd5000;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Reset setup: only home channel 0 as a slot.
    visit(8'd0, 32'd10, 16'd3, 16'd9, 16'd2, 16'd1);
    visit(8'd7, 32'd10, 16'd3, 16'd9, 16'd2, 16'd1);   // unknown channel
    visit(8'd0, 32'd20, 16'd0, 16'd0, 16'd0, 16'd0);
    query(32'd30, 8'd0, 9'd0);                           // home excluded
    query(32'd30, 8'd1, 9'd0);
    drain();

    // Full list, home added as ninth slot, boot in the list.
    set_registers(64'hFF80_7F40_240B_0601, 4'd8, 8'h0C, 8'h24, 5'd16, 32'd1000);
    visit(8'h01, 32'd100, 16'hFFFF, 16'hFFFF, 16'h0000, 16'hFFFF);  // largest score
    visit(8'h01, 32'd200, 16'h0000, 16'h0000, 16'h0000, 16'h0000);
    visit(8'h24, 32'd300, 16'd5, 16'd10, 16'd20, 16'd0);            // busy floored
    visit(8'h24, 32'd310, 16'd5, 16'd0, 16'hFFFF, 16'd0);
    visit(8'h0C, 32'd300, 16'd10, 16'd0, 16'd0, 16'd0);            // ties the boot pick
    visit(8'h0C, 32'd310, 16'd0, 16'd0, 16'd0, 16'd0);
    visit(8'h06, 32'd300, 16'd0, 16'd10, 16'd0, 16'd0);            // ties, neither boot nor home
    visit(8'h06, 32'd320, 16'd0, 16'd0, 16'd0, 16'd0);
    visit(8'hFF, 32'd2000, 16'd1, 16'd0, 16'd0, 16'd0);             // future visits
    visit(8'hFF, 32'd3000, 16'd1, 16'd0, 16'd0, 16'd0);
    visit(8'h33, 32'd300, 16'd1, 16'd1, 16'd1, 16'd1);              // unknown
    query(32'd1000, 8'h24, 9'd0);
    query(32'd1000, 8'h00, 9'h1FF);
    query(32'd1000, 8'hFF, 9'h0F0);
    query(32'd1300, 8'h00, 9'd0);                                   // edge of the age limit
    query(32'hFFFF_FFFF, 8'h00, 9'd0);                              // everything stale
    drain();

    // Duplicates, home listed, count and window past their limits, age zero.
    set_registers(64'h0505_0505_0505_0505, 4'd15, 8'h05, 8'h05, 5'd31, 32'd0);
    for (int i = 0; i < 18; i++) visit(8'h05, 32'hFFFF_FFF0, any_count(), any_count(),
                                       any_count(), any_count());
    query(32'hFFFF_FFF0, 8'h00, 9'd0);
    drain();

    // Window of zero keeps nothing; widest age.
    set_registers(64'h0302_0100_0000_0000, 4'd0, 8'hAA, 8'h00, 5'd0, 32'hFFFF_FFFF);
    visit(8'hAA, 32'd0, 16'd1, 16'd1, 16'd0, 16'd1);
    query(32'd0, 8'h00, 9'd0);
    drain();

    // Random phases across many setups; keep stored visits across some changes.
    for (int p = 0; p < 9; p++) begin
      list = {$urandom, $urandom};
      if (p % 3 == 0) list = list & 64'h0707_0707_0707_0707;   // force duplicates
      count_sel = 4'($urandom_range(0, 15));
      list_sel = list;
      home = $urandom_range(0, 1) ? list[8*$urandom_range(0, 7) +: 8] : 8'($urandom);
      home_sel = home;
      boot = $urandom_range(0, 1) ? slot_channel() : 8'($urandom);
      set_registers(list, count_sel, home, boot,
                    (p == 4) ? 5'd1 : ($urandom_range(0, 3) == 0 ? 5'($urandom)
                                                           : 5'($urandom_range(2, 16))),
                    (p == 5) ? 32'd0 : (p == 6) ? 32'hFFFF_FFFF
                                                : 32'($urandom_range(200, 2000)));
      random_phase(36);
      if (p == 2) begin
        // Shrink the window over the stored visits; query before and after a visit.
        set_registers(list_sel, count_sel, home_sel, boot, 5'd2, 32'hFFFF_FFFF);
        query(now_ms, 8'h00, 9'd0);
        visit(slot_channel(), now_ms, any_count(), any_count(), any_count(), any_count());
        query(now_ms, 8'h00, 9'd0);
        drain();
      end
    end

    if (fail_count == 0) $display("tb: success");
    else $display("tb: failure");
    $finish;
  end

endmodule
